>>> rtl/pfnv12_pkg.sv
// Shared types, constants and helper functions for the pixel format to NV12 core.
// Used by pfnv12_csc, pfnv12_outq and pixel_format_to_nv12_core. No dependencies.
`default_nettype none

package pfnv12_pkg;

    // Default frame limits for the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register reset values and the absolute size cap.
    localparam logic [12:0] RST_WIDTH  = 13'd1920;
    localparam logic [12:0] RST_HEIGHT = 13'd1080;
    localparam logic [12:0] SIZE_MIN   = 13'd2;
    localparam logic [12:0] SIZE_CAP   = 13'd4096;

    // Depth of the result queue in front of the master port.
    localparam int OQ_DEPTH = 4;

    // BT.601 limited-range coefficients.
    localparam logic [7:0] Y601_R = 8'd66;
    localparam logic [7:0] Y601_G = 8'd129;
    localparam logic [7:0] Y601_B = 8'd25;
    localparam logic [7:0] U601_R = 8'd38;
    localparam logic [7:0] U601_G = 8'd74;
    localparam logic [7:0] V601_G = 8'd94;
    localparam logic [7:0] V601_B = 8'd18;

    // BT.709 limited-range coefficients.
    localparam logic [7:0] Y709_R = 8'd47;
    localparam logic [7:0] Y709_G = 8'd157;
    localparam logic [7:0] Y709_B = 8'd16;
    localparam logic [7:0] U709_R = 8'd26;
    localparam logic [7:0] U709_G = 8'd87;
    localparam logic [7:0] V709_G = 8'd102;
    localparam logic [7:0] V709_B = 8'd10;

    // Shared coefficient of the dominant term of Cb and Cr.
    localparam logic [7:0] C_MAIN = 8'd112;

    // Rounding and offset terms of the matrix.
    localparam logic [15:0] Y_ROUND  = 16'd128;
    localparam logic [7:0]  Y_OFFSET = 8'd16;
    localparam logic [15:0] C_OFFSET = 16'd32896;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SRC_FMT = 2'd0,
        CFG_BT709   = 2'd1,
        CFG_WIDTH   = 2'd2,
        CFG_HEIGHT  = 2'd3
    } t_cfg_idx;

    // Source pixel formats.
    typedef enum logic [1:0] {
        FMT_NV12  = 2'd0,
        FMT_NV16  = 2'd1,
        FMT_NV24  = 2'd2,
        FMT_BGR24 = 2'd3
    } t_src_fmt;

    // One source pixel as it arrives on the slave port.
    typedef struct packed {
        logic [7:0] luma_or_blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
    } t_pixel;

    // Luma and chroma of one pixel after the color stage.
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    // One result word for the master port.
    typedef struct packed {
        logic        is_chroma;
        logic [7:0]  sample_y;
        logic [7:0]  sample_u;
        logic [7:0]  sample_v;
        logic [11:0] out_col;
        logic [11:0] out_row;
        logic        last_of_run;
    } t_result;

    // Push request into the result queue: a luma word and, optionally, a chroma word.
    typedef struct packed {
        logic    push;
        logic    pair;
        t_result luma;
        t_result chroma;
    } t_oq_push;

    // Effective frame size: even, clamped to the cap and to the build limit.
    function automatic logic [12:0] eff_size(input logic [12:0] reg_val,
                                             input logic [13:0] max_val);
        logic [12:0] s;
        s = {reg_val[12:1], 1'b0};
        if (s < SIZE_MIN) s = SIZE_MIN;
        if (s > SIZE_CAP) s = SIZE_CAP;
        if ({1'b0, s} > max_val) s = 13'({max_val[13:1], 1'b0});
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfnv12_csc.sv
// Two-stage color conversion: constant products, then sums into limited-range YCbCr.
// Depends on pfnv12_pkg for coefficients and the pixel and YUV types.
`default_nettype none

module pfnv12_csc (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic               i_bgr,
    input  wire logic               i_bt709,
    input  wire pfnv12_pkg::t_pixel i_pix,
    output pfnv12_pkg::t_yuv        o_yuv
);

    // Coefficient selection by matrix.
    logic [7:0] c_yr, c_yg, c_yb, c_ur, c_ug, c_vg, c_vb;

    always_comb begin
        c_yr = i_bt709 ? pfnv12_pkg::Y709_R : pfnv12_pkg::Y601_R;
        c_yg = i_bt709 ? pfnv12_pkg::Y709_G : pfnv12_pkg::Y601_G;
        c_yb = i_bt709 ? pfnv12_pkg::Y709_B : pfnv12_pkg::Y601_B;
        c_ur = i_bt709 ? pfnv12_pkg::U709_R : pfnv12_pkg::U601_R;
        c_ug = i_bt709 ? pfnv12_pkg::U709_G : pfnv12_pkg::U601_G;
        c_vg = i_bt709 ? pfnv12_pkg::V709_G : pfnv12_pkg::V601_G;
        c_vb = i_bt709 ? pfnv12_pkg::V709_B : pfnv12_pkg::V601_B;
    end

    // First stage: the nine 8x8 products, plus the raw bytes for pass-through.
    logic [15:0] r_py_r, r_py_g, r_py_b;
    logic [15:0] r_pu_r, r_pu_g, r_pu_b;
    logic [15:0] r_pv_r, r_pv_g, r_pv_b;
    logic [7:0]  r_raw_y, r_raw_u, r_raw_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py_r  <= 16'(i_pix.red)          * 16'(c_yr);
            r_py_g  <= 16'(i_pix.green)        * 16'(c_yg);
            r_py_b  <= 16'(i_pix.luma_or_blue) * 16'(c_yb);
            r_pu_r  <= 16'(i_pix.red)          * 16'(c_ur);
            r_pu_g  <= 16'(i_pix.green)        * 16'(c_ug);
            r_pu_b  <= 16'(i_pix.luma_or_blue) * 16'(pfnv12_pkg::C_MAIN);
            r_pv_r  <= 16'(i_pix.red)          * 16'(pfnv12_pkg::C_MAIN);
            r_pv_g  <= 16'(i_pix.green)        * 16'(c_vg);
            r_pv_b  <= 16'(i_pix.luma_or_blue) * 16'(c_vb);
            r_raw_y <= i_pix.luma_or_blue;
            r_raw_u <= i_pix.chroma_u;
            r_raw_v <= i_pix.chroma_v;
        end
    end

    // Second stage sums. The offsets keep every sum inside 0..65535, so the
    // top byte is the floor shift and no clipping is ever needed.
    logic [15:0] y_sum, u_sum, v_sum;

    always_comb begin
        y_sum = r_py_r + r_py_g + r_py_b + pfnv12_pkg::Y_ROUND;
        u_sum = pfnv12_pkg::C_OFFSET + r_pu_b - r_pu_r - r_pu_g;
        v_sum = pfnv12_pkg::C_OFFSET + r_pv_r - r_pv_g - r_pv_b;
    end

    // Second stage register: converted or passed-through sample.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_bgr) begin
                o_yuv.y <= y_sum[15:8] + pfnv12_pkg::Y_OFFSET;
                o_yuv.u <= u_sum[15:8];
                o_yuv.v <= v_sum[15:8];
            end else begin
                o_yuv.y <= r_raw_y;
                o_yuv.u <= r_raw_u;
                o_yuv.v <= r_raw_v;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfnv12_outq.sv
// Small result queue in front of the master port; takes one or two words a cycle.
// Depends on pfnv12_pkg for the result and push types and the queue depth.
`default_nettype none

module pfnv12_outq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pfnv12_pkg::t_oq_push i_push,
    output logic                      o_room,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output pfnv12_pkg::t_result       o_head
);

    localparam int PTR_W = $clog2(pfnv12_pkg::OQ_DEPTH);
    localparam int CNT_W = $clog2(pfnv12_pkg::OQ_DEPTH + 1);

    pfnv12_pkg::t_result r_slot [pfnv12_pkg::OQ_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                pop, push_two;

    // Room for a full pair is judged on the registered count alone.
    assign o_room   = (r_count <= CNT_W'(pfnv12_pkg::OQ_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_slot[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign push_two = i_push.push && i_push.pair;

    always_comb begin
        n_count = r_count + CNT_W'(i_push.push) + CNT_W'(push_two) - CNT_W'(pop);
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (pop) r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (i_push.push) r_wr_ptr <= r_wr_ptr + PTR_W'(1) + PTR_W'(push_two);
        end
    end

    // Storage: the luma word first, the chroma word behind it.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wr_ptr] <= i_push.luma;
            if (push_two) r_slot[r_wr_ptr + PTR_W'(1)] <= i_push.chroma;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pixel_format_to_nv12_core.sv
// Top level of the pixel format to NV12 converter: counters, line store, chroma merge.
// Depends on pfnv12_pkg, pfnv12_csc and pfnv12_outq.
//
// Pixels enter in raster order, one word per clock unless the pipeline stalls, and
// each gives a luma word; the pixel at an odd row and odd column also gives the
// 4:2:0 chroma word of its 2x2 block, right behind the luma word. The master port
// moves one word per cycle while the receiver is ready, so on odd rows the output
// port, not the input side, sets the pace. A pixel passes the stage-one and
// stage-two registers before it is written into the output queue. The even-row
// chroma sums of each column pair sit in a line store of MAX_WIDTH/2 entries of
// 18 bits, written once per pair on each even row and read through a registered
// port as the pipeline advances; it has no clearing pass and needs none, since
// every entry is written on an even row before the odd row reads it. The user must
// write registers only while the block is idle; the block does not enforce it.
// A write of the format or of either size restarts the frame at row 0, column 0.
`default_nettype none

module pixel_format_to_nv12_core #(
    parameter int MAX_WIDTH  = pfnv12_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pfnv12_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    // Pixel input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: luma_or_blue[7:0], green[15:8], red[23:16], chroma_u[31:24], chroma_v[39:32]
    input  wire logic [39:0] s_axis_tdata,
    // Result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: sample_y[7:0], sample_u[15:8], sample_v[23:16], out_col[35:24], out_row[47:36]
    output logic [47:0]      m_axis_tdata,
    // tuser: is_chroma[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int          LS_DEPTH = MAX_WIDTH / 2;
    localparam int          ADDR_W   = $clog2(LS_DEPTH);
    localparam logic [13:0] MAX_W14  = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14  = 14'(MAX_HEIGHT);
    localparam logic [11:0] LAST_COL_RST =
        12'(pfnv12_pkg::eff_size(pfnv12_pkg::RST_WIDTH, MAX_W14) - 13'd1);
    localparam logic [11:0] LAST_ROW_RST =
        12'(pfnv12_pkg::eff_size(pfnv12_pkg::RST_HEIGHT, MAX_H14) - 13'd1);

    // Configuration and frame position.
    pfnv12_pkg::t_src_fmt r_src_fmt;
    logic                 r_bt709;
    logic [11:0]          r_last_col, r_last_row;
    logic [11:0]          r_col, r_row;
    logic [11:0]          n_col, n_row;
    logic                 restart;

    // Pipeline control.
    logic        adv, accept;
    logic        r_s1_valid, r_s2_valid;
    logic [11:0] r_s1_col, r_s1_row, r_s2_col, r_s2_row;

    // Chroma state.
    logic [8:0]  r_pend_u, r_pend_v;
    logic [17:0] r_line_store [LS_DEPTH];
    logic [17:0] r_ls_rdata;

    pfnv12_pkg::t_pixel   pix;
    pfnv12_pkg::t_yuv     s2_yuv;
    pfnv12_pkg::t_oq_push oq_push;
    pfnv12_pkg::t_result  oq_head;
    logic                 oq_room;

    // Unpack the input word.
    always_comb begin
        pix.luma_or_blue = s_axis_tdata[7:0];
        pix.green        = s_axis_tdata[15:8];
        pix.red          = s_axis_tdata[23:16];
        pix.chroma_u     = s_axis_tdata[31:24];
        pix.chroma_v     = s_axis_tdata[39:32];
    end

    // The whole pipeline moves together; it stalls only when stage two holds a
    // pixel and the queue lacks room for a luma and chroma pair.
    assign adv           = !r_s2_valid || oq_room;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Raster position of the next pixel.
    always_comb begin
        n_col = r_col + 12'd1;
        n_row = r_row;
        if (r_col >= r_last_col) begin
            n_col = '0;
            n_row = (r_row >= r_last_row) ? 12'd0 : r_row + 12'd1;
        end
    end

    // Frame restart on a format or size write.
    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            unique case (pfnv12_pkg::t_cfg_idx'(i_cfg_idx))
                pfnv12_pkg::CFG_SRC_FMT,
                pfnv12_pkg::CFG_WIDTH,
                pfnv12_pkg::CFG_HEIGHT: restart = 1'b1;
                default:                restart = 1'b0;
            endcase
        end
    end

    // Configuration registers and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt  <= pfnv12_pkg::FMT_NV12;
            r_bt709    <= 1'b0;
            r_last_col <= LAST_COL_RST;
            r_last_row <= LAST_ROW_RST;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (pfnv12_pkg::t_cfg_idx'(i_cfg_idx))
                    pfnv12_pkg::CFG_SRC_FMT:
                        r_src_fmt <= pfnv12_pkg::t_src_fmt'(i_cfg_data[1:0]);
                    pfnv12_pkg::CFG_BT709:
                        r_bt709 <= i_cfg_data[0];
                    pfnv12_pkg::CFG_WIDTH:
                        r_last_col <= 12'(pfnv12_pkg::eff_size(i_cfg_data, MAX_W14) - 13'd1);
                    pfnv12_pkg::CFG_HEIGHT:
                        r_last_row <= 12'(pfnv12_pkg::eff_size(i_cfg_data, MAX_H14) - 13'd1);
                    default: ;
                endcase
            end
            if (restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage positions.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
        end
    end

    // Color conversion, aligned with the two stages.
    pfnv12_csc u_csc (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_bgr   (r_src_fmt == pfnv12_pkg::FMT_BGR24),
        .i_bt709 (r_bt709),
        .i_pix   (pix),
        .o_yuv   (s2_yuv)
    );

    // Stage-two decode of the pixel's place in its 2x2 block.
    logic       s2_col_odd, s2_row_odd, s2_fire, sum_cols;
    logic [8:0] st_u, st_v, eu, ev;
    logic [9:0] half_u, half_v;
    logic [10:0] quad_u, quad_v;
    logic [8:0] avg_u, avg_v;
    logic [7:0] out_u, out_v;

    assign s2_col_odd = r_s2_col[0];
    assign s2_row_odd = r_s2_row[0];
    assign s2_fire    = r_s2_valid && adv;
    assign eu         = r_ls_rdata[17:9];
    assign ev         = r_ls_rdata[8:0];

    always_comb begin
        case (r_src_fmt) inside
            pfnv12_pkg::FMT_NV24, pfnv12_pkg::FMT_BGR24: sum_cols = 1'b1;
            default:                                     sum_cols = 1'b0;
        endcase
    end

    // Even-row value stored for the pair: one sample, or both columns summed.
    always_comb begin
        st_u = r_pend_u + (sum_cols ? {1'b0, s2_yuv.u} : 9'd0);
        st_v = r_pend_v + (sum_cols ? {1'b0, s2_yuv.v} : 9'd0);
    end

    // Odd-row merge into the block's chroma pair, rounded where averaged and clipped.
    always_comb begin
        half_u = {1'b0, eu} + {1'b0, r_pend_u} + 10'd1;
        half_v = {1'b0, ev} + {1'b0, r_pend_v} + 10'd1;
        quad_u = {2'b0, eu} + {2'b0, r_pend_u} + {3'b0, s2_yuv.u} + 11'd2;
        quad_v = {2'b0, ev} + {2'b0, r_pend_v} + {3'b0, s2_yuv.v} + 11'd2;
        case (r_src_fmt)
            pfnv12_pkg::FMT_NV12: begin
                avg_u = eu;
                avg_v = ev;
            end
            pfnv12_pkg::FMT_NV16: begin
                avg_u = half_u[9:1];
                avg_v = half_v[9:1];
            end
            default: begin
                avg_u = quad_u[10:2];
                avg_v = quad_v[10:2];
            end
        endcase
        out_u = avg_u[8] ? 8'hFF : avg_u[7:0];
        out_v = avg_v[8] ? 8'hFF : avg_v[7:0];
    end

    // Even-column sample of the current pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_pend_u <= '0;
            r_pend_v <= '0;
        end else if (s2_fire && !s2_col_odd) begin
            r_pend_u <= {1'b0, s2_yuv.u};
            r_pend_v <= {1'b0, s2_yuv.v};
        end
    end

    // Line store: written from stage two on even rows, read for the pixel leaving
    // stage one. A pair is read at least two pixels after its write, so the write
    // always lands first.
    always_ff @(posedge i_clk) begin
        if (s2_fire && s2_col_odd && !s2_row_odd) begin
            r_line_store[ADDR_W'(r_s2_col >> 1)] <= {st_u, st_v};
        end
        if (adv) begin
            r_ls_rdata <= r_line_store[ADDR_W'(r_s1_col >> 1)];
        end
    end

    // Result words into the queue.
    always_comb begin
        oq_push.push               = s2_fire;
        oq_push.pair               = s2_col_odd && s2_row_odd;
        oq_push.luma.is_chroma     = 1'b0;
        oq_push.luma.sample_y      = s2_yuv.y;
        oq_push.luma.sample_u      = '0;
        oq_push.luma.sample_v      = '0;
        oq_push.luma.out_col       = r_s2_col;
        oq_push.luma.out_row       = r_s2_row;
        oq_push.luma.last_of_run   = !(s2_col_odd && s2_row_odd);
        oq_push.chroma.is_chroma   = 1'b1;
        oq_push.chroma.sample_y    = '0;
        oq_push.chroma.sample_u    = out_u;
        oq_push.chroma.sample_v    = out_v;
        oq_push.chroma.out_col     = r_s2_col - 12'd1;
        oq_push.chroma.out_row     = r_s2_row >> 1;
        oq_push.chroma.last_of_run = 1'b1;
    end

    pfnv12_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .o_room  (oq_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (oq_head)
    );

    // Pack the output word.
    assign m_axis_tdata = {oq_head.out_row, oq_head.out_col, oq_head.sample_v,
                           oq_head.sample_u, oq_head.sample_y};
    assign m_axis_tuser = oq_head.is_chroma;
    assign m_axis_tlast = oq_head.last_of_run;

endmodule

`default_nettype wire

>>> rtl/pfnv12_checker.sv
// Port-level checks for pixel_format_to_nv12_core, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module pfnv12_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // A chroma word ends its run, carries no luma and sits on an even column.
    a_chroma_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[24])
        else $error("malformed chroma word");

    // A luma word carries no chroma.
    a_luma_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("luma word with chroma bits");

    // Only the odd-row, odd-column pixel has a chroma word behind it.
    a_pair_site: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser && !m_axis_tlast |->
            m_axis_tdata[24] && m_axis_tdata[36])
        else $error("chroma pair announced at wrong position");

    // The chroma word is already queued when its luma word leaves.
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser)
        else $error("chroma word missing after its luma word");

endmodule

bind pixel_format_to_nv12_core pfnv12_checker u_pfnv12_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> test/tb_pixel_format_to_nv12_core.sv
// Testbench for pixel_format_to_nv12_core: directed and random pixel streams.
// It predicts every luma and chroma word and checks each output word against it.
// Depends on pfnv12_pkg and the RTL of the core only.
`timescale 1ns / 100ps

module tb_pixel_format_to_nv12_core;

    localparam int FRAME_CAP = 4096;
    localparam int PAIR_MASK = FRAME_CAP / 2 - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = pfnv12_pkg::CFG_SRC_FMT;
    logic [12:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: luma_or_blue[7:0], green[15:8], red[23:16], chroma_u[31:24], chroma_v[39:32]
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: sample_y[7:0], sample_u[15:8], sample_v[23:16], out_col[35:24], out_row[47:36]
    logic [47:0] m_axis_tdata;
    // tuser: is_chroma[0]
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Idle and stall odds in percent, set per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Predictor copy of the registers and of the frame state.
    pfnv12_pkg::t_src_fmt src_fmt = pfnv12_pkg::FMT_NV12;
    logic        bt709 = 1'b0;
    logic [12:0] width_reg = 13'd1920;
    logic [12:0] height_reg = 13'd1080;
    int          col_pos = 0;
    int          row_pos = 0;
    int          pend_u = 0;
    int          pend_v = 0;
    logic [17:0] even_row_sums [0:PAIR_MASK];

    pfnv12_pkg::t_result expected_words [$];
    pfnv12_pkg::t_result want;

    pixel_format_to_nv12_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Effective frame dimension: even, at least 2, at most the cap.
    function automatic int frame_dim(input logic [12:0] raw);
        int s;
        s = int'(raw & 13'h1FFE);
        if (s < 2) s = 2;
        if (s > FRAME_CAP) s = FRAME_CAP;
        return s;
    endfunction

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [39:0] pixel_word(input logic [7:0] y, input logic [7:0] g,
                                               input logic [7:0] r, input logic [7:0] u,
                                               input logic [7:0] v);
        return {v, u, r, g, y};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < 100)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        mismatch_count++;
    endtask

    // Works out the luma word, and the chroma word after an odd row and odd column,
    // that one accepted pixel causes, and advances the frame position.
    task automatic predict_nv12_words(input logic [39:0] px);
        int w, h, b, g, r, yv, uv, vv, su, sv, eu, ev, ou, ov, pair;
        pfnv12_pkg::t_result luma_w, chroma_w;
        w = frame_dim(width_reg);
        h = frame_dim(height_reg);
        b = px[7:0];
        g = px[15:8];
        r = px[23:16];
        if (src_fmt == pfnv12_pkg::FMT_BGR24) begin
            if (bt709) begin
                yv = ((47 * r + 157 * g + 16 * b + 128) >>> 8) + 16;
                uv = (32896 + 112 * b - 26 * r - 87 * g) >>> 8;
                vv = (32896 + 112 * r - 102 * g - 10 * b) >>> 8;
            end else begin
                yv = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
                uv = (32896 + 112 * b - 38 * r - 74 * g) >>> 8;
                vv = (32896 + 112 * r - 94 * g - 18 * b) >>> 8;
            end
        end else begin
            yv = b;
            uv = px[31:24];
            vv = px[39:32];
        end
        uv = clamp_byte(uv);
        vv = clamp_byte(vv);
        pair = (col_pos >> 1) & PAIR_MASK;

        luma_w = '0;
        luma_w.sample_y = clamp_byte(yv);
        luma_w.out_col = 12'(col_pos);
        luma_w.out_row = 12'(row_pos);
        luma_w.last_of_run = 1'b1;
        chroma_w = '0;

        if (col_pos % 2 == 0) begin
            // Even column: hold this sample for the pair.
            pend_u = uv;
            pend_v = vv;
        end else if (row_pos % 2 == 0) begin
            // Even row, odd column: park the pair in the line store.
            su = pend_u;
            sv = pend_v;
            if (src_fmt == pfnv12_pkg::FMT_NV24 || src_fmt == pfnv12_pkg::FMT_BGR24) begin
                su += uv;
                sv += vv;
            end
            even_row_sums[pair] = {9'(su), 9'(sv)};
        end else begin
            // Odd row, odd column: merge with the stored even row.
            eu = even_row_sums[pair][17:9];
            ev = even_row_sums[pair][8:0];
            case (src_fmt)
                pfnv12_pkg::FMT_NV12: begin
                    ou = eu;
                    ov = ev;
                end
                pfnv12_pkg::FMT_NV16: begin
                    ou = (eu + pend_u + 1) >> 1;
                    ov = (ev + pend_v + 1) >> 1;
                end
                default: begin
                    ou = (eu + pend_u + uv + 2) >> 2;
                    ov = (ev + pend_v + vv + 2) >> 2;
                end
            endcase
            luma_w.last_of_run = 1'b0;
            chroma_w.is_chroma = 1'b1;
            chroma_w.sample_u = clamp_byte(ou);
            chroma_w.sample_v = clamp_byte(ov);
            chroma_w.out_col = 12'(col_pos - 1);
            chroma_w.out_row = 12'(row_pos >> 1);
            chroma_w.last_of_run = 1'b1;
        end

        expected_words.push_back(luma_w);
        if (chroma_w.is_chroma) expected_words.push_back(chroma_w);

        // Raster advance with wrap at the end of the frame.
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    // Register write; the format and both sizes restart the frame.
    task automatic write_register(input pfnv12_pkg::t_cfg_idx idx, input logic [12:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pfnv12_pkg::CFG_SRC_FMT: src_fmt = pfnv12_pkg::t_src_fmt'(value[1:0]);
            pfnv12_pkg::CFG_BT709:   bt709 = value[0];
            pfnv12_pkg::CFG_WIDTH:   width_reg = value;
            pfnv12_pkg::CFG_HEIGHT:  height_reg = value;
        endcase
        if (idx != pfnv12_pkg::CFG_BT709) begin
            col_pos = 0;
            row_pos = 0;
            pend_u = 0;
            pend_v = 0;
        end
    endtask

    // Holds the input off until every expected word has come out.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    task automatic program_frame(input pfnv12_pkg::t_src_fmt fmt, input logic use709,
                                 input logic [12:0] wr, input logic [12:0] hr);
        wait_for_idle();
        write_register(pfnv12_pkg::CFG_SRC_FMT, 13'(fmt));
        write_register(pfnv12_pkg::CFG_BT709, 13'(use709));
        write_register(pfnv12_pkg::CFG_WIDTH, wr);
        write_register(pfnv12_pkg::CFG_HEIGHT, hr);
    endtask

    // Sends one pixel word, with a random gap before it, and predicts its results.
    task automatic send_pixel(input logic [39:0] px);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_nv12_words(px);
    endtask

    // Result checker: random back-pressure and field-by-field compare.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected", 1, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_axis_tuser !== want.is_chroma)
                        report_mismatch("is_chroma", m_axis_tuser, want.is_chroma);
                    if (m_axis_tdata[7:0] !== want.sample_y)
                        report_mismatch("sample_y", m_axis_tdata[7:0], want.sample_y);
                    if (m_axis_tdata[15:8] !== want.sample_u)
                        report_mismatch("sample_u", m_axis_tdata[15:8], want.sample_u);
                    if (m_axis_tdata[23:16] !== want.sample_v)
                        report_mismatch("sample_v", m_axis_tdata[23:16], want.sample_v);
                    if (m_axis_tdata[35:24] !== want.out_col)
                        report_mismatch("out_col", m_axis_tdata[35:24], want.out_col);
                    if (m_axis_tdata[47:36] !== want.out_row)
                        report_mismatch("out_row", m_axis_tdata[47:36], want.out_row);
                    if (m_axis_tlast !== want.last_of_run)
                        report_mismatch("last_of_run", m_axis_tlast, want.last_of_run);
                end
            end
        end
    end

    // One 2x2 frame per chroma format, with byte extremes in every field.
    task automatic test_chroma_formats();
        pfnv12_pkg::t_src_fmt fmts [3] = '{pfnv12_pkg::FMT_NV12, pfnv12_pkg::FMT_NV16,
                                           pfnv12_pkg::FMT_NV24};
        logic [39:0] block [4];
        block = '{pixel_word(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF),
                  pixel_word(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00),
                  pixel_word(8'h80, 8'h7F, 8'h01, 8'hFF, 8'hFF),
                  pixel_word(8'h01, 8'hFE, 8'h80, 8'h00, 8'h01)};
        foreach (fmts[i]) begin
            program_frame(fmts[i], 1'b0, 13'd2, 13'd2);
            foreach (block[j]) send_pixel(block[j]);
        end
    endtask

    // All eight RGB cube corners, four per matrix; the matrix switch keeps the position.
    task automatic test_bgr_matrices();
        program_frame(pfnv12_pkg::FMT_BGR24, 1'b0, 13'd2, 13'd2);
        send_pixel(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_pixel(pixel_word(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_pixel(pixel_word(8'h00, 8'h00, 8'hFF, 8'h12, 8'h34));
        send_pixel(pixel_word(8'hFF, 8'h00, 8'h00, 8'h56, 8'h78));
        wait_for_idle();
        write_register(pfnv12_pkg::CFG_BT709, 13'd1);
        send_pixel(pixel_word(8'h00, 8'hFF, 8'h00, 8'h9A, 8'hBC));
        send_pixel(pixel_word(8'hFF, 8'hFF, 8'h00, 8'hDE, 8'hF0));
        send_pixel(pixel_word(8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_pixel(pixel_word(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Oversized, odd and zero sizes, then a format write in the middle of a frame.
    task automatic test_size_limits();
        program_frame(pfnv12_pkg::FMT_NV12, 1'b0, 13'h1FFF, 13'h1FFF);
        repeat (3) send_pixel(pixel_word(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h96));
        program_frame(pfnv12_pkg::FMT_NV16, 1'b1, 13'd1, 13'd0);
        send_pixel(pixel_word(8'h11, 8'h22, 8'h33, 8'h44, 8'h55));
        wait_for_idle();
        write_register(pfnv12_pkg::CFG_SRC_FMT, 13'(pfnv12_pkg::FMT_NV24));
        repeat (5) send_pixel({8'($urandom), 32'($urandom)});
        program_frame(pfnv12_pkg::FMT_BGR24, 1'b1, 13'd3, 13'd5);
        repeat (4) send_pixel({8'($urandom), 32'($urandom)});
    endtask

    // Random frames: mostly small sizes so chroma words come often.
    task automatic test_random_stream(input int item_budget, input int send_pct,
                                      input int recv_pct);
        int          sent, n_items, w, h;
        logic [12:0] wr, hr;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < item_budget) begin
            if (sent > 0 && $urandom_range(0, 3) == 0) begin
                // Matrix switch only: the frame carries on.
                wait_for_idle();
                write_register(pfnv12_pkg::CFG_BT709, 13'($urandom_range(0, 1)));
                n_items = $urandom_range(4, 40);
            end else begin
                wr = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 20));
                hr = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(0, 12));
                program_frame(pfnv12_pkg::t_src_fmt'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)), wr, hr);
                w = frame_dim(wr);
                h = frame_dim(hr);
                if (w * h <= 120)
                    n_items = w * h * $urandom_range(1, 3) + $urandom_range(0, 2 * w);
                else
                    n_items = $urandom_range(8, 60);
            end
            if (n_items > item_budget - sent) n_items = item_budget - sent;
            repeat (n_items) begin
                if ($urandom_range(0, 49) == 0) wait_for_idle();
                send_pixel({8'($urandom), 32'($urandom)});
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_stall_pct = 30;
        test_chroma_formats();
        test_bgr_matrices();
        test_size_limits();
        test_random_stream(230, 0, 0);
        test_random_stream(230, 55, 0);
        test_random_stream(230, 0, 55);
        test_random_stream(230, 27, 27);
        wait_for_idle();
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words still expected", expected_words.size(), 0);
        if (mismatch_count == 0) begin
            $display("tb_pixel_format_to_nv12_core OK");
        end else begin
            $display("tb_pixel_format_to_nv12_core NOT OK");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #5_000_000;
        $display("tb_pixel_format_to_nv12_core NOT OK");
        $finish;
    end

endmodule
